### rtl/core/gpba_pkg.sv
// Package for the growing page bump allocator: codes, widths, state and
// result structs, and the power-of-two round-up. No dependencies.
`timescale 1ns / 1ps

package gpba_pkg;

   // Page table depth and derived widths
   localparam int MAX_PAGES   = 16;
   localparam int PAGE_CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int PAGE_IDX_W  = 4;
   localparam int BYTE_W      = 32;
   localparam int CSR_IDX_W   = 1;

   localparam logic [BYTE_W-1:0] MIN_PAGE_RESET = 32'd65536;
   localparam logic [BYTE_W-1:0] MAX_PAGE_RESET = 32'd16777216;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TOO_BIG = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PAGE = 1'b0,
      CSR_MAX_PAGE = 1'b1
   } csr_idx_type;

   // Allocator state: pages in use, newest page size and its fill offset
   typedef struct packed {
      logic [PAGE_CNT_W-1:0] count;
      logic [BYTE_W-1:0]     psize;
      logic [BYTE_W-1:0]     usage;
   } state_type;

   // One result word
   typedef struct packed {
      status_type            status;
      logic [PAGE_IDX_W-1:0] page_index;
      logic [BYTE_W-1:0]     begin_offset;
      logic [BYTE_W-1:0]     end_offset;
      logic [BYTE_W-1:0]     page_size;
      logic                  new_page;
   } rsp_type;

   // Round up to a power of two; zero rounds to one
   function automatic logic [BYTE_W+1:0] round_pow2(input logic [BYTE_W+1:0] v);
      logic [BYTE_W+1:0] t;
      t = v - (BYTE_W+2)'(1);
      t = t | (t >> 1);
      t = t | (t >> 2);
      t = t | (t >> 4);
      t = t | (t >> 8);
      t = t | (t >> 16);
      t = t | (t >> 32);
      if (v == '0) begin
         return (BYTE_W+2)'(1);
      end
      return t + (BYTE_W+2)'(1);
   endfunction

endpackage

### rtl/core/gpba_if.sv
// Channel interfaces of the growing page bump allocator: request, result
// and register write. Depends on gpba_pkg.
`timescale 1ns / 1ps

interface gpba_req_if;
   logic                         valid;
   logic                         ready;
   gpba_pkg::cmd_type            cmd;
   logic [gpba_pkg::BYTE_W-1:0]  size_bytes;

   modport source (output valid, cmd, size_bytes, input ready);
   modport sink   (input valid, cmd, size_bytes, output ready);
endinterface

interface gpba_rsp_if;
   logic                             valid;
   logic                             ready;
   gpba_pkg::status_type             status;
   logic [gpba_pkg::PAGE_IDX_W-1:0]  page_index;
   logic [gpba_pkg::BYTE_W-1:0]      begin_offset;
   logic [gpba_pkg::BYTE_W-1:0]      end_offset;
   logic [gpba_pkg::BYTE_W-1:0]      page_size;
   logic                             new_page;

   modport source (output valid, status, page_index, begin_offset, end_offset,
                   page_size, new_page, input ready);
   modport sink   (input valid, status, page_index, begin_offset, end_offset,
                   page_size, new_page, output ready);
endinterface

interface gpba_csr_if;
   logic                           valid;
   logic                           ready;
   gpba_pkg::csr_idx_type          index;
   logic [gpba_pkg::BYTE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/growing_page_bump_allocator.sv
// Top level of the growing page bump allocator: input register, allocation
// logic, result register and page registers.
// Depends on gpba_pkg, gpba_if and gpba_calc.
//
// Usage:
//   req_ch carries one word per request: cmd (allocate or release all pages)
//   and size_bytes. rsp_ch returns exactly one word per request, in order:
//   status, page_index, begin/end offsets, page_size and new_page.
//   csr_ch writes min_page_size (index 0) and max_page_size (index 1); it is
//   always ready and must only be used while no request is in flight.
//   A request is held in the input register; its result is loaded into the
//   result register. Throughput: one request per cycle while rsp_ch is ready;
//   page state updates in the same cycle the result register loads, so the
//   next request sees it. When rsp_ch stalls, the result register holds and
//   the input register keeps one more request; req_ch.ready drops only when
//   both are full. Reset: synchronous, active high; clears all pages, empties
//   both registers and restores the default page size limits.
`timescale 1ns / 1ps

module growing_page_bump_allocator (
   input  logic       clock,
   input  logic       reset,
   gpba_req_if.sink   req_ch,
   gpba_rsp_if.source rsp_ch,
   gpba_csr_if.sink   csr_ch
);
   import gpba_pkg::*;

   logic              in_vld_ff, in_vld_in;
   cmd_type           in_cmd_ff;
   logic [BYTE_W-1:0] in_size_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_type           rsp_ff;
   state_type         state_ff;
   logic [BYTE_W-1:0] min_page_ff;
   logic [BYTE_W-1:0] max_page_ff;
   rsp_type           calc_rsp;
   state_type         calc_nxt;
   logic              req_take;
   logic              adv;

   // Handshakes: advance the stage when the result slot is free or drains
   assign adv          = in_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || adv;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign in_vld_in  = req_take ? 1'b1 : (adv ? 1'b0 : in_vld_ff);
   assign rsp_vld_in = adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_vld_ff);

   gpba_calc u_calc (
      .cmd        (in_cmd_ff),
      .size_bytes (in_size_ff),
      .cur        (state_ff),
      .min_page   (min_page_ff),
      .max_page   (max_page_ff),
      .rsp        (calc_rsp),
      .nxt        (calc_nxt)
   );

   // Control: valid flags and page state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (adv) begin
            state_ff <= calc_nxt;
         end
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_page_ff <= MIN_PAGE_RESET;
         max_page_ff <= MAX_PAGE_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MIN_PAGE: min_page_ff <= csr_ch.data;
            CSR_MAX_PAGE: max_page_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Payload: capture the request word, load the result word
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_ch.cmd;
         in_size_ff <= req_ch.size_bytes;
      end
      if (adv) begin
         rsp_ff <= calc_rsp;
      end
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.page_index   = rsp_ff.page_index;
   assign rsp_ch.begin_offset = rsp_ff.begin_offset;
   assign rsp_ch.end_offset   = rsp_ff.end_offset;
   assign rsp_ch.page_size    = rsp_ff.page_size;
   assign rsp_ch.new_page     = rsp_ff.new_page;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= PAGE_CNT_W'(MAX_PAGES))
      else $error("page count above table depth");

   a_usage_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff.usage <= state_ff.psize)
      else $error("fill offset beyond newest page");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      adv && (in_cmd_ff == CMD_RELEASE) |=> (state_ff.count == '0))
      else $error("release left pages behind");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_ff.status != ST_OK) |->
         (!rsp_ff.new_page && rsp_ff.page_size == '0 && rsp_ff.end_offset == '0))
      else $error("error result carries a range");

   a_new_page_origin: assert property (@(posedge clock) disable iff (reset)
      adv && calc_rsp.new_page |=> (state_ff.usage == rsp_ff.end_offset
         && rsp_ff.begin_offset == '0))
      else $error("new page range not at offset zero");
`endif

endmodule

### rtl/core/gpba_calc.sv
// Single-pass allocation logic: fit check, new page sizing, error checks
// and next state. Depends on gpba_pkg.
`timescale 1ns / 1ps

module gpba_calc (
   input  gpba_pkg::cmd_type                cmd,
   input  logic [gpba_pkg::BYTE_W-1:0]      size_bytes,
   input  gpba_pkg::state_type              cur,
   input  logic [gpba_pkg::BYTE_W-1:0]      min_page,
   input  logic [gpba_pkg::BYTE_W-1:0]      max_page,
   output gpba_pkg::rsp_type                rsp,
   output gpba_pkg::state_type              nxt
);
   import gpba_pkg::*;

   logic                  have_page;
   logic [BYTE_W:0]       sum;
   logic                  fits;
   logic [BYTE_W-1:0]     want_lo;
   logic [BYTE_W:0]       dbl;
   logic [BYTE_W:0]       want;
   logic [BYTE_W+1:0]     rounded;
   logic [BYTE_W-1:0]     newsize;
   logic                  too_big;
   logic                  full;
   logic [PAGE_CNT_W-1:0] cnt_inc;
   logic [PAGE_CNT_W-1:0] cnt_last;

   // Fit check against the newest page
   assign have_page = (cur.count != '0);
   assign sum       = {1'b0, cur.usage} + {1'b0, size_bytes};
   assign fits      = have_page && (sum <= {1'b0, cur.psize});

   // Size a new page: max of minimum, request and double, round, clamp
   assign want_lo = (size_bytes > min_page) ? size_bytes : min_page;
   assign dbl     = {cur.psize, 1'b0};
   assign want    = (have_page && (dbl > {1'b0, want_lo})) ? dbl : {1'b0, want_lo};
   assign rounded = round_pow2({1'b0, want});
   assign newsize = (rounded > {2'b00, max_page}) ? max_page : rounded[BYTE_W-1:0];

   assign too_big  = (size_bytes > newsize);
   assign full     = (cur.count >= PAGE_CNT_W'(MAX_PAGES));
   assign cnt_inc  = cur.count + PAGE_CNT_W'(1);
   assign cnt_last = cur.count - PAGE_CNT_W'(1);

   // Pick the result and the next state
   always_comb begin
      rsp = '0;
      rsp.status = ST_OK;
      nxt = cur;
      if (cmd == CMD_RELEASE) begin
         nxt = '0;
      end else if (fits) begin
         rsp.page_index   = cnt_last[PAGE_IDX_W-1:0];
         rsp.begin_offset = cur.usage;
         rsp.end_offset   = sum[BYTE_W-1:0];
         rsp.page_size    = cur.psize;
         nxt.usage        = sum[BYTE_W-1:0];
      end else if (too_big) begin
         rsp.status = ST_TOO_BIG;
      end else if (full) begin
         rsp.status = ST_FULL;
      end else begin
         rsp.page_index   = cur.count[PAGE_IDX_W-1:0];
         rsp.end_offset   = size_bytes;
         rsp.page_size    = newsize;
         rsp.new_page     = 1'b1;
         nxt.count        = cnt_inc;
         nxt.psize        = newsize;
         nxt.usage        = size_bytes;
      end
   end

endmodule
